### rtl/core/bdasc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdasc_pkg;

    // width of the converted binary value
    localparam int VALUE_WIDTH = 32;
    // decimal digits needed for VALUE_WIDTH bits: floor(w * log10(2)) + 1
    localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int IDX_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int STEP_W      = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int IN_W        = 32;
    localparam int ASCII_W     = 6;

    localparam logic [ASCII_W-1:0] ASCII_ZERO   = ASCII_W'(48);
    localparam logic [STEP_W-1:0]  LAST_STEP    = STEP_W'(VALUE_WIDTH - 1);
    localparam logic [3:0]         BCD_ADJ_MIN  = 4'd5;
    localparam logic [3:0]         BCD_ADJ      = 4'd3;

    typedef logic [DIGITS-1:0][3:0] t_bcd;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic find;
        logic emit;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic shift_done;
        logic digit_last;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/core/bdasc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bdasc_ctrl
    import bdasc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy
);

    typedef enum logic [3:0] {
        t_IDLE    = 4'b0001,
        t_CONVERT = 4'b0010,
        t_FIND    = 4'b0100,
        t_EMIT    = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            t_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = t_CONVERT;
                end
            end
            t_CONVERT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = t_FIND;
                end
            end
            t_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = t_EMIT;
            end
            t_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.digit_last) begin
                    n_state = t_IDLE;
                end
            end
            default: begin
                n_state = t_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != t_IDLE);

endmodule

`default_nettype wire

### rtl/core/bdasc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bdasc_datapath
    import bdasc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire logic [IN_W-1:0]  i_value,
    output t_dp_sts               o_sts,
    output logic                  o_valid,
    output logic [ASCII_W-1:0]    o_ascii_digit,
    output logic                  o_last
);

    logic [VALUE_WIDTH-1:0] r_bin;
    t_bcd                   r_bcd;
    t_bcd                   n_bcd_adj;
    logic [STEP_W-1:0]      r_step;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       n_idx_lead;
    logic [3:0]             n_digit;
    logic                   r_valid;
    logic [ASCII_W-1:0]     r_ascii;
    logic                   r_last;

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            n_bcd_adj[d] = (r_bcd[d] >= BCD_ADJ_MIN) ? r_bcd[d] + BCD_ADJ : r_bcd[d];
        end
    end

    // position of the most significant non-zero digit, zero when all are zero
    always_comb begin
        n_idx_lead = '0;
        for (int d = 1; d < DIGITS; d++) begin
            if (r_bcd[d] != 4'd0) begin
                n_idx_lead = IDX_W'(d);
            end
        end
    end

    assign n_digit = r_bcd[r_idx];

    // shift-and-add-3 conversion and digit pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin  <= VALUE_WIDTH'(i_value);
            r_bcd  <= '0;
            r_step <= '0;
        end else if (i_cmd.shift) begin
            {r_bcd, r_bin} <= {n_bcd_adj, r_bin} << 1;
            r_step         <= r_step + STEP_W'(1);
        end
        if (i_cmd.find) begin
            r_idx <= n_idx_lead;
        end else if (i_cmd.emit && (r_idx != '0)) begin
            r_idx <= r_idx - IDX_W'(1);
        end
    end

    // output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    // output character register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ascii <= ASCII_ZERO + {{(ASCII_W-4){1'b0}}, n_digit};
            r_last  <= (r_idx == '0);
        end
    end

    assign o_sts.shift_done = (r_step == LAST_STEP);
    assign o_sts.digit_last = (r_idx == '0);
    assign o_valid          = r_valid;
    assign o_ascii_digit    = r_ascii;
    assign o_last           = r_last;

endmodule

`default_nettype wire

### rtl/core/binary_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts one unsigned binary value into its decimal ASCII digits, most
// significant first, without leading zeros; zero gives the single character
// '0'. A transaction is taken when start is high while busy is low. Each
// character appears on o_ascii_digit for exactly one cycle with o_valid high,
// and o_last marks the final digit; there is no back-pressure, so the receiver
// must take every character as it comes. One value passes through a load, one
// shift-and-add-3 step per input bit, a search for the leading digit and then
// its digits at one per cycle; busy drops in the cycle that shows the last
// digit, and the next start may be given then.

module binary_to_decimal_ascii_unit
    import bdasc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [IN_W-1:0]    i_value,
    output logic                    o_valid,
    output logic [ASCII_W-1:0]      o_ascii_digit,
    output logic                    o_last
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencing
    bdasc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // conversion and character output
    bdasc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_value       (i_value),
        .o_sts         (w_sts),
        .o_valid       (o_valid),
        .o_ascii_digit (o_ascii_digit),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

### rtl/core/bdasc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bdasc_checker
    import bdasc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire logic [ASCII_W-1:0] o_ascii_digit,
    input wire logic               o_last
);

    // an accepted transaction makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // characters are decimal digits only
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ascii_digit >= ASCII_ZERO) && (o_ascii_digit <= ASCII_ZERO + 6'd9))
        else $error("character outside '0' to '9'");

    // more digits follow while still busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("digit without last mark while idle");

    // the final digit coincides with the end of the transaction
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("busy still high on the final digit");

    // busy drops only together with the final digit
    a_fall_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_valid && o_last)
        else $error("busy dropped without a final digit");

endmodule

bind binary_to_decimal_ascii_unit bdasc_checker u_bdasc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_ascii_digit (o_ascii_digit),
    .o_last        (o_last)
);

`default_nettype wire

### sim/binary_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 1ps

module binary_to_decimal_ascii_unit_tb;
    import bdasc_pkg::*;

    localparam int DEC_BASE     = 10;
    localparam int RANDOM_ITEMS = 300;
    localparam int SETTLE_TICKS = 60;

    // one expected character of a decimal run
    typedef struct {
        logic [ASCII_W-1:0] digit;
        logic               last;
    } char_exp_t;

    // holds the characters still owed by the block, oldest first
    class digit_scoreboard;
        char_exp_t expected_chars[$];
        int        mismatches    = 0;
        int        values_noted  = 0;
        int        chars_checked = 0;

        // work out the decimal run of an accepted value
        function void note_value(logic [IN_W-1:0] value);
            logic [63:0] rem;
            logic [63:0] mask;
            logic [3:0]  digits[$];
            char_exp_t   c;
            mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
            rem  = 64'(value) & mask;
            do begin
                digits.push_front(4'(rem % DEC_BASE));
                rem = rem / DEC_BASE;
            end while (rem != 0);
            foreach (digits[k]) begin
                c.digit = ASCII_ZERO + ASCII_W'(digits[k]);
                c.last  = (k == digits.size() - 1);
                expected_chars.push_back(c);
            end
            values_noted++;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        // compare one emitted character with the oldest one owed
        function void check_char(logic [ASCII_W-1:0] digit, logic last);
            char_exp_t want;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected character digit=%0d last=%0b", digit, last));
                return;
            end
            want = expected_chars.pop_front();
            chars_checked++;
            if (digit !== want.digit || last !== want.last)
                report($sformatf({"character mismatch: expected digit=%0d last=%0b, ",
                                  "got digit=%0d last=%0b"},
                                 want.digit, want.last, digit, last));
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic [IN_W-1:0]    i_value = '0;
    logic               busy;
    logic               o_valid;
    logic [ASCII_W-1:0] o_ascii_digit;
    logic               o_last;

    digit_scoreboard sb = new();

    binary_to_decimal_ascii_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_ascii_digit (o_ascii_digit),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // watch both sides of the block at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_value(i_value);
            if (o_valid)
                sb.check_char(o_ascii_digit, o_last);
        end
    end

    // present one value and hold it until the block takes the transaction
    task automatic send_value(input logic [IN_W-1:0] value);
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    // idle the sender with noise on the value port
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) begin
                i_value <= $urandom();
                @(posedge i_clk);
            end
        end
    endtask

    // stop sending until every owed character has come out
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // values of mixed magnitude, many near powers of ten
    function automatic logic [IN_W-1:0] pick_value();
        logic [IN_W-1:0] p;
        int              k;
        case ($urandom_range(0, 3))
            0: pick_value = $urandom();
            1: pick_value = $urandom() >> $urandom_range(0, 31);
            2: begin
                p = 1;
                k = $urandom_range(0, 9);
                repeat (k) p = p * DEC_BASE;
                pick_value = p + $urandom_range(0, 2) - 1;
            end
            default: pick_value = $urandom_range(0, 20);
        endcase
    endfunction

    // stimulus
    initial begin
        logic [IN_W-1:0] directed[$];
        logic [IN_W-1:0] p;
        int              sent;
        int              burst;
        int              gap;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, powers of ten and the values just below them
        directed = '{32'd0, 32'd1, 32'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        p = 10;
        repeat (9) begin
            directed.push_back(p);
            directed.push_back(p - 1);
            p = p * DEC_BASE;
        end
        foreach (directed[k])
            send_value(directed[k]);
        drain();

        // back-to-back stretch with no idling
        repeat (30)
            send_value(pick_value());
        sent = 30;

        // bursts with random gaps, now and then waiting for the block to empty
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst)
                send_value(pick_value());
            sent += burst;
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 5);
                default: gap = $urandom_range(6, 60);
            endcase
            hold_off(gap);
            if ($urandom_range(0, 15) == 0)
                drain();
        end

        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("run covered %0d values (zero, all ones, powers of ten and random magnitudes)",
                 sb.values_noted);
        $display("%0d characters checked, %0d mismatches", sb.chars_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("binary_to_decimal_ascii_unit verification clean");
        end else begin
            if (sb.pending() != 0)
                $display("%0d characters never arrived", sb.pending());
            $display("binary_to_decimal_ascii_unit verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout with %0d characters outstanding", sb.pending());
        $display("binary_to_decimal_ascii_unit verification failed");
        $finish;
    end

endmodule

### binary_to_decimal_ascii_unit.f
rtl/core/bdasc_pkg.sv
rtl/core/bdasc_ctrl.sv
rtl/core/bdasc_datapath.sv
rtl/core/binary_to_decimal_ascii_unit.sv
rtl/core/bdasc_checker.sv
sim/binary_to_decimal_ascii_unit_tb.sv
